// File: rtl/bps_pkg.sv
// Package for the beep pattern sequencer: request kinds, output field positions,
// the step table and the per-pattern length and repeat lookups.
// No dependencies.
package bps_pkg;

  localparam int PATTERN_COUNT = 7;
  localparam int MAX_STEPS     = 8;
  localparam int ROM_ROWS      = 7;
  localparam int ROM_COLS      = 8;

  localparam int DUR_W  = 16;
  localparam int STEP_W = 3;
  localparam int PAT_W  = 3;
  localparam int LEN_W  = 4;

  // request kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PLAY = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  // result tdata bit positions
  localparam int OUT_BUZZER = 0;
  localparam int OUT_BUSY   = 1;
  localparam int OUT_STEP_LO = 2;
  localparam int OUT_STEP_HI = 4;
  localparam int OUT_DONE   = 5;

  typedef logic [DUR_W:0] step_entry_t;  // [16] level, [15:0] duration in ms

  localparam step_entry_t LVL_ON = step_entry_t'(17'h10000);

  localparam step_entry_t STEP_ROM [0:ROM_ROWS*ROM_COLS-1] = '{
    LVL_ON | 17'd100, 17'd50,  LVL_ON | 17'd100, 17'd0,
    17'd0,            17'd0,   17'd0,            17'd0,
    LVL_ON | 17'd100, 17'd0,   17'd0,            17'd0,
    17'd0,            17'd0,   17'd0,            17'd0,
    LVL_ON | 17'd50,  17'd50,  LVL_ON | 17'd250, 17'd0,
    17'd0,            17'd0,   17'd0,            17'd0,
    LVL_ON | 17'd250, 17'd50,  LVL_ON | 17'd50,  17'd0,
    17'd0,            17'd0,   17'd0,            17'd0,
    LVL_ON | 17'd100, 17'd100, LVL_ON | 17'd100, 17'd100,
    LVL_ON | 17'd100, 17'd100, LVL_ON | 17'd100, 17'd100,
    LVL_ON | 17'd50,  17'd200, 17'd0,            17'd0,
    17'd0,            17'd0,   17'd0,            17'd0,
    LVL_ON | 17'd50,  17'd0,   17'd0,            17'd0,
    17'd0,            17'd0,   17'd0,            17'd0
  };

  localparam logic [LEN_W-1:0] ROW_LEN [0:ROM_ROWS-1] = '{
    4'd3, 4'd1, 4'd3, 4'd3, 4'd8, 4'd2, 4'd1
  };
  localparam logic ROW_REP [0:ROM_ROWS-1] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
  };

  function automatic step_entry_t step_entry(logic [PAT_W-1:0] p, logic [STEP_W-1:0] s);
    step_entry_t e;
    e = '0;
    if (int'(p) < ROM_ROWS && int'(s) < ROM_COLS) begin
      e = STEP_ROM[int'(p) * ROM_COLS + int'(s)];
    end
    return e;
  endfunction

  // pattern length, clamped to the step limit and table width, at least one
  function automatic logic [LEN_W-1:0] pat_len(logic [PAT_W-1:0] p);
    int n;
    n = 1;
    if (int'(p) < ROM_ROWS) begin
      n = int'(ROW_LEN[p]);
    end
    if (n > MAX_STEPS) n = MAX_STEPS;
    if (n > ROM_COLS) n = ROM_COLS;
    if (n < 1) n = 1;
    return LEN_W'(n);
  endfunction

  function automatic logic pat_rep(logic [PAT_W-1:0] p);
    logic r;
    r = 1'b0;
    if (int'(p) < ROM_ROWS) begin
      r = ROW_REP[p];
    end
    return r;
  endfunction

endpackage

// File: rtl/beep_pattern_sequencer_top.sv
// Beep pattern sequencer top level: request decode, step sequencing and result register.
// Depends on bps_pkg.
//
//  channel   dir  handshake            payload
//  in_       in   in_tvalid/in_tready  tuser: kind[1:0]; tdata: pattern[2:0], zero pad
//  out_      out  out_tvalid/out_tready tdata: buzzer_drive, busy_res, step_now[2:0],
//                                        pattern_done, zero pad
//  cfg_      in   cfg_wr_en            cfg_wr_data: mute
//
// One request per cycle unless stalled; the registered result shows the next cycle.
// A new request is taken whenever the result register is empty or being drained.
// Each request does the single step-table read and 16-bit countdown combinationally.
// rst_n (synchronous) clears the sequencer to idle, quiet mode off, no result pending.
// A stalled result holds in the result register while in_tready stays low.
module beep_pattern_sequencer_top
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] pattern, [7:3] zero
  input  logic [1:0] in_tuser,   // [1:0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] buzzer_drive, [1] busy_res, [4:2] step_now,
                                 // [5] pattern_done, [7:6] zero
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic              quiet_r;
  logic              playing_r, playing_nxt;
  logic [PAT_W-1:0]  sel_r, sel_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DUR_W-1:0]  ms_r, ms_nxt;
  logic              level_r, level_nxt;
  logic              out_valid_r;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              accept;
  logic              done;
  logic              load_en;
  logic [STEP_W-1:0] load_pos;
  logic [DUR_W-1:0]  ms_dec;
  logic [LEN_W-1:0]  step_inc;
  logic [PAT_W-1:0]  req_pat;
  step_entry_t       entry;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign req_pat    = in_tdata[PAT_W-1:0];

  assign ms_dec   = (ms_r != '0) ? ms_r - DUR_W'(1) : '0;
  assign step_inc = {1'b0, step_r} + LEN_W'(1);

  always_comb begin
    playing_nxt = playing_r;
    sel_nxt     = sel_r;
    step_nxt    = step_r;
    ms_nxt      = ms_r;
    level_nxt   = level_r;
    done        = 1'b0;
    load_en     = 1'b0;
    load_pos    = '0;

    case (kind_t'(in_tuser))
      KIND_TICK: begin
        if (playing_r) begin
          ms_nxt = ms_dec;
          if (ms_dec == '0) begin
            if (step_inc < pat_len(sel_r)) begin
              load_en  = 1'b1;
              load_pos = step_inc[STEP_W-1:0];
            end else if (pat_rep(sel_r)) begin
              load_en = 1'b1;
            end else begin
              playing_nxt = 1'b0;
              step_nxt    = '0;
              ms_nxt      = '0;
              done        = 1'b1;
            end
          end
        end
      end
      KIND_PLAY: begin
        if (int'(req_pat) < PATTERN_COUNT && int'(req_pat) < ROM_ROWS && !quiet_r) begin
          sel_nxt     = req_pat;
          playing_nxt = 1'b1;
          load_en     = 1'b1;
        end
      end
      KIND_STOP: begin
        playing_nxt = 1'b0;
        step_nxt    = '0;
        ms_nxt      = '0;
      end
      default: ;
    endcase

    entry = step_entry(sel_nxt, load_pos);
    if (load_en) begin
      step_nxt  = load_pos;
      ms_nxt    = entry[DUR_W-1:0];
      level_nxt = entry[DUR_W];
    end

    out_data_nxt              = '0;
    out_data_nxt[OUT_BUZZER]  = playing_nxt && level_nxt;
    out_data_nxt[OUT_BUSY]    = playing_nxt;
    out_data_nxt[OUT_STEP_HI:OUT_STEP_LO] = step_nxt;
    out_data_nxt[OUT_DONE]    = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_r     <= 1'b0;
      playing_r   <= 1'b0;
      sel_r       <= '0;
      step_r      <= '0;
      ms_r        <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        quiet_r <= cfg_wr_data;
      end
      if (accept) begin
        playing_r   <= playing_nxt;
        sel_r       <= sel_nxt;
        step_r      <= step_nxt;
        ms_r        <= ms_nxt;
        level_r     <= level_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/bps_checker.sv
// Port-level checker for the beep pattern sequencer, bound to the top level.
// Depends on bps_pkg and beep_pattern_sequencer_top.
module bps_checker
  import bps_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing pending straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // idle means silent and back at step 0
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_BUSY] |->
      !out_tdata[OUT_BUZZER] && out_tdata[OUT_STEP_HI:OUT_STEP_LO] == '0)
    else $error("drive or step set while idle");

  // done only at the point of going idle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE] |-> !out_tdata[OUT_BUSY])
    else $error("done while still busy");

  // a stop request yields an idle result on the next cycle
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_STOP |=>
      out_tvalid && !out_tdata[OUT_BUSY] && !out_tdata[OUT_DONE])
    else $error("stop did not force idle");

endmodule

bind beep_pattern_sequencer_top bps_checker u_bps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/beep_result_checker.sv
// Result checker for the beep pattern sequencer: tracks every accepted request,
// predicts the result and compares it field by field. Depends on bps_pkg.
module beep_result_checker
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              buzzer_drive;
    logic              busy_res;
    logic [STEP_W-1:0] step_now;
    logic              pattern_done;
  } beep_result_t;

  beep_result_t      expected_beeps[$];

  logic              quiet_q;
  logic              seq_active;
  logic [PAT_W-1:0]  cur_pattern;
  logic [STEP_W-1:0] cur_step;
  logic [DUR_W-1:0]  ms_remaining;

  function automatic step_entry_t rom_word(logic [STEP_W-1:0] s);
    return STEP_ROM[int'(cur_pattern) * ROM_COLS + int'(s)];
  endfunction

  function automatic void enter_step(logic [STEP_W-1:0] s);
    step_entry_t e;
    cur_step     = s;
    e            = rom_word(s);
    ms_remaining = e[DUR_W-1:0];
  endfunction

  function automatic void to_idle();
    seq_active   = 1'b0;
    cur_step     = '0;
    ms_remaining = '0;
  endfunction

  function automatic beep_result_t predict_beep(logic [1:0] kind, logic [PAT_W-1:0] pat);
    beep_result_t r;
    int           steps;
    int           nxt;
    step_entry_t  e;
    r.pattern_done = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (seq_active) begin
          if (ms_remaining != 0) ms_remaining = ms_remaining - 1'b1;
          if (ms_remaining == 0) begin
            steps = int'(ROW_LEN[cur_pattern]);
            if (steps > MAX_STEPS) steps = MAX_STEPS;
            if (steps < 1) steps = 1;
            nxt = int'(cur_step) + 1;
            if (nxt < steps) begin
              enter_step(STEP_W'(nxt));
            end else if (ROW_REP[cur_pattern]) begin
              enter_step('0);
            end else begin
              to_idle();
              r.pattern_done = 1'b1;
            end
          end
        end
      end
      KIND_PLAY: begin
        if (int'(pat) < PATTERN_COUNT && int'(pat) < ROM_ROWS && !quiet_q) begin
          cur_pattern = pat;
          seq_active  = 1'b1;
          enter_step('0);
        end
      end
      KIND_STOP: to_idle();
      default: ;  // unknown kind leaves the state alone
    endcase
    e              = rom_word(cur_step);
    r.buzzer_drive = seq_active && e[DUR_W];
    r.busy_res     = seq_active;
    r.step_now     = cur_step;
    return r;
  endfunction

  always @(posedge clk) begin
    beep_result_t exp_r;
    if (!rst_n) begin
      expected_beeps.delete();
      fail_count  = 0;
      quiet_q     = 1'b0;
      cur_pattern = '0;
      to_idle();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_beeps.size() == 0) begin
          $error("result with no request pending, tdata %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_beeps.pop_front();
          if (out_tdata[OUT_BUZZER] !== exp_r.buzzer_drive) begin
            $error("buzzer_drive: expected %0d, got %0d", exp_r.buzzer_drive,
                   out_tdata[OUT_BUZZER]);
            fail_count++;
          end
          if (out_tdata[OUT_BUSY] !== exp_r.busy_res) begin
            $error("busy_res: expected %0d, got %0d", exp_r.busy_res, out_tdata[OUT_BUSY]);
            fail_count++;
          end
          if (out_tdata[OUT_STEP_HI:OUT_STEP_LO] !== exp_r.step_now) begin
            $error("step_now: expected %0d, got %0d", exp_r.step_now,
                   out_tdata[OUT_STEP_HI:OUT_STEP_LO]);
            fail_count++;
          end
          if (out_tdata[OUT_DONE] !== exp_r.pattern_done) begin
            $error("pattern_done: expected %0d, got %0d", exp_r.pattern_done,
                   out_tdata[OUT_DONE]);
            fail_count++;
          end
          if (out_tdata[7:6] !== 2'b00) begin
            $error("pad: expected 0, got %0d", out_tdata[7:6]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_beeps.push_back(predict_beep(in_tuser, in_tdata[PAT_W-1:0]));
      // register write lands after this edge
      if (cfg_wr_en) quiet_q = cfg_wr_data;
    end
    pending = expected_beeps.size();
  end

endmodule

// File: sim/beep_pattern_sequencer_top_tb.sv
// Testbench top for the beep pattern sequencer: clock, reset, request stimulus,
// receiver stalls and verdict. Depends on bps_pkg, beep_result_checker and the RTL.
module beep_pattern_sequencer_top_tb
  import bps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]       KIND_UNKNOWN = 2'd3;
  localparam logic [PAT_W-1:0] PAT_INVALID  = 3'd7;
  localparam int               IDLE_LIMIT   = 5000;
  localparam int               HOLD_CYCLES  = 300;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [2:0] pattern, [7:3] zero
  logic [1:0] in_tuser;   // [1:0] kind
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] buzzer_drive, [1] busy_res, [4:2] step_now, [5] pattern_done
  logic       cfg_wr_en;
  logic       cfg_wr_data;

  int fail_count;
  int pending;
  int idle_cycles;
  int sent;
  bit calm;
  bit hold_go;

  beep_pattern_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  beep_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [PAT_W-1:0] pat);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, pat};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // quiet mode only changes once every result is back
  task automatic write_quiet(logic q);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_request(KIND_TICK, PAT_W'($urandom_range(0, 7)));
  endtask

  // mostly play-then-tick sequences so patterns run to their end, plus noise
  task automatic random_phase(int n_items);
    int               stop_at;
    int               len;
    logic [PAT_W-1:0] p;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 2))
            0: p = 3'd1;
            1: p = 3'd5;
            default: p = 3'd6;
          endcase
        end else begin
          p = PAT_W'($urandom_range(0, 6));
        end
        send_request(KIND_PLAY, p);
        len = $urandom_range(1, 320);
        if (p == 3'd4 && $urandom_range(0, 3) == 0) len = $urandom_range(700, 850);
        // keep the phase close to its item budget
        if (len > stop_at - sent) len = stop_at - sent;
        run_ticks(len);
        if ($urandom_range(0, 3) == 0) send_request(KIND_STOP, PAT_W'($urandom_range(0, 7)));
      end else begin
        send_request(2'($urandom_range(0, 3)), PAT_W'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    rst_n       = 1'b0;
    sent        = 0;
    calm        = 1'b0;
    hold_go     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    write_quiet(1'b0);
    send_request(KIND_TICK, 3'd0);           // tick while idle
    send_request(KIND_STOP, 3'd0);           // stop while idle
    send_request(KIND_UNKNOWN, 3'd5);
    send_request(KIND_PLAY, PAT_INVALID);
    send_request(KIND_PLAY, 3'd0);
    send_request(KIND_TICK, 3'd7);
    send_request(KIND_UNKNOWN, 3'd2);
    send_request(KIND_PLAY, 3'd1);           // restart over a running pattern
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_PLAY, 3'd2);
    send_request(KIND_PLAY, 3'd3);
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_PLAY, 3'd5);
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_PLAY, 3'd6);
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_PLAY, PAT_INVALID);
    send_request(KIND_STOP, 3'd7);
    send_request(KIND_PLAY, 3'd4);
    write_quiet(1'b1);
    // pattern 4 keeps running while plays are refused, until the stop ends it
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_PLAY, 3'd2);
    send_request(KIND_PLAY, 3'd0);
    send_request(KIND_TICK, 3'd0);
    send_request(KIND_STOP, 3'd0);
    send_request(KIND_PLAY, 3'd6);

    write_quiet(1'b0);
    hold_go = 1'b1;
    random_phase(550);
    write_quiet(1'b1);
    random_phase(250);
    write_quiet(1'b0);
    random_phase(550);
    calm = 1'b1;
    random_phase(400);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
